@@ src/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is applied
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that a condition never occurs, quiet while reset is applied
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/lac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lac_pkg
// Types, constants and helpers for the look-at yaw/pitch core.
// ---------------------------------------------------------------------------
package lac_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 51;   // CORDIC vector width
    localparam int ZW           = 25;   // angle accumulator, Q20 radians
    localparam int ATAN_LEN     = 24;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
    localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [15:0]   PI_Q213 = 16'sd25736;

    localparam logic [1:0] ACT_WORLD  = 2'd0;
    localparam logic [1:0] ACT_LOCAL  = 2'd1;
    localparam logic [1:0] ACT_DIRECT = 2'd2;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    localparam logic [20:0] ATAN_Q20 [0:ATAN_LEN-1] = '{
        21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451, 21'd32757,
        21'd16383, 21'd8192, 21'd4096, 21'd2048, 21'd1024, 21'd512,
        21'd256, 21'd128, 21'd64, 21'd32, 21'd16, 21'd8, 21'd4, 21'd2,
        21'd1, 21'd0, 21'd0, 21'd0
    };

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] node_local_x;
        logic signed [31:0] node_local_y;
        logic signed [31:0] node_local_z;
        logic signed [31:0] node_world_x;
        logic signed [31:0] node_world_y;
        logic signed [31:0] node_world_z;
    } req_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } rsp_t;

    // clamp a 33-bit sum to the 32-bit position range
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] == v[31])
            r = v[31:0];
        else if (v[32])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    // round half up from Q20 to Q2.13 and clamp to +-pi
    function automatic logic signed [15:0] to_q213(input logic signed [ZW-1:0] z);
        logic signed [ZW:0]   s;
        logic signed [ZW-7:0] a;
        logic signed [15:0]   r;
        s = {z[ZW-1], z} + (ZW+1)'(64);
        a = s[ZW:7];
        if (a > (ZW-6)'(PI_Q213))
            r = PI_Q213;
        else if (a < -(ZW-6)'(PI_Q213))
            r = -PI_Q213;
        else
            r = a[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/lac_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lac_cordic
// Pipelined CORDIC vectoring pass: quadrant fold, then one iteration per stage.
// ---------------------------------------------------------------------------
module lac_cordic
    import lac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] in_x,
    input  wire logic signed [CW-1:0] in_y,
    output logic                      out_valid,
    output logic signed [CW-1:0]      out_x,
    output logic signed [ZW-1:0]      out_z
);

    logic                 v_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];

    // fold the left half plane onto the right by a quarter turn
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_x < 0) begin
            if (in_y >= 0)
            begin
                x_reg[0] <= in_y;
                y_reg[0] <= -in_x;
                z_reg[0] <= HALF_PI_Q20;
            end
            else
            begin
                x_reg[0] <= -in_y;
                y_reg[0] <= in_x;
                z_reg[0] <= -HALF_PI_Q20;
            end
        end
        else
        begin
            x_reg[0] <= in_x;
            y_reg[0] <= in_y;
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] ang;
        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign ang = ZW'(ATAN_Q20[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ang;
            end
            else if (y_reg[i] < 0)
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ang;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i];
                y_reg[i+1] <= y_reg[i];
                z_reg[i+1] <= z_reg[i];
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_x     = x_reg[CORDIC_STEPS];
    assign out_z     = z_reg[CORDIC_STEPS];

endmodule
`default_nettype wire

@@ src/camera_look_at_yaw_pitch_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// camera_look_at_yaw_pitch_core
// Yaw and pitch that aim a camera at a target point, via two CORDIC passes.
// ---------------------------------------------------------------------------
// Accepts one request every cycle (busy stays low) and returns each result
// as a one-cycle done pulse via the target, delta, yaw CORDIC (fold stage,
// then one stage per iteration), gain-multiply, pitch CORDIC and rounding
// stages. Results cannot be held off. Offsets are written over the APB port;
// the user must write them only while idle, which the block does not enforce.
module camera_look_at_yaw_pitch_core
    import lac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LAT = 2 * CORDIC_STEPS + 6;

    logic signed [31:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_OFFSET_X: offset_x_reg <= pwdata;
                REG_OFFSET_Y: offset_y_reg <= pwdata;
                REG_OFFSET_Z: offset_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OFFSET_X: prdata = offset_x_reg;
            REG_OFFSET_Y: prdata = offset_y_reg;
            REG_OFFSET_Z: prdata = offset_z_reg;
            default:      prdata = '0;
        endcase
    end

    // stage 1: target point
    logic               s1_valid_reg;
    logic signed [31:0] s1_cx_reg, s1_cy_reg, s1_cz_reg;
    logic signed [31:0] s1_tx_reg, s1_ty_reg, s1_tz_reg;
    logic signed [31:0] src_x, src_y, src_z;
    logic signed [31:0] tx_next, ty_next, tz_next;

    always_comb
    begin
        if (req.action == ACT_LOCAL)
        begin
            src_x = req.node_local_x;
            src_y = req.node_local_y;
            src_z = req.node_local_z;
        end
        else
        begin
            src_x = req.node_world_x;
            src_y = req.node_world_y;
            src_z = req.node_world_z;
        end
        if (req.action == ACT_DIRECT)
        begin
            tx_next = src_x;
            ty_next = src_y;
            tz_next = src_z;
        end
        else
        begin
            tx_next = sat32(33'(src_x) + 33'(offset_x_reg));
            ty_next = sat32(33'(src_y) + 33'(offset_y_reg));
            tz_next = sat32(33'(src_z) + 33'(offset_z_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_cx_reg <= req.cam_x;
        s1_cy_reg <= req.cam_y;
        s1_cz_reg <= req.cam_z;
        s1_tx_reg <= tx_next;
        s1_ty_reg <= ty_next;
        s1_tz_reg <= tz_next;
    end

    // stage 2: delta = camera - target
    logic               s2_valid_reg;
    logic signed [31:0] s2_dx_reg, s2_dy_reg, s2_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_dx_reg <= sat32(33'(s1_cx_reg) - 33'(s1_tx_reg));
        s2_dy_reg <= sat32(33'(s1_cy_reg) - 33'(s1_ty_reg));
        s2_dz_reg <= sat32(33'(s1_cz_reg) - 33'(s1_tz_reg));
    end

    // yaw pass; dy rides alongside in a delay line
    logic                 p1_valid;
    logic signed [CW-1:0] p1_x;
    logic signed [ZW-1:0] p1_z;
    logic signed [31:0]   dy_dly_reg [0:CORDIC_STEPS];

    lac_cordic u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_x      (CW'($signed({s2_dz_reg, 16'h0000}))),
        .in_y      (CW'($signed({s2_dx_reg, 16'h0000}))),
        .out_valid (p1_valid),
        .out_x     (p1_x),
        .out_z     (p1_z)
    );

    always_ff @(posedge clk)
    begin
        dy_dly_reg[0] <= s2_dy_reg;
        for (int i = 1; i <= CORDIC_STEPS; i++)
            dy_dly_reg[i] <= dy_dly_reg[i-1];
    end

    // remove the CORDIC gain
    localparam int PW = CW - 8 + 17;
    logic                 m_valid_reg;
    logic signed [PW-1:0] m_prod_reg;
    logic signed [31:0]   m_dy_reg;
    logic signed [ZW-1:0] m_yaw_reg;
    logic signed [CW-1:0] h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= p1_valid;
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg <= PW'(p1_x >>> 8) * PW'($signed({1'b0, INV_GAIN_Q16}));
        m_dy_reg   <= dy_dly_reg[CORDIC_STEPS];
        m_yaw_reg  <= p1_z;
    end

    assign h = m_prod_reg[CW+7:8];

    // pitch pass; yaw angle rides alongside
    logic                 p2_valid;
    logic signed [CW-1:0] p2_x;
    logic signed [ZW-1:0] p2_z;
    logic signed [ZW-1:0] yaw_dly_reg [0:CORDIC_STEPS];

    lac_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .in_x      (h),
        .in_y      (CW'($signed({m_dy_reg, 16'h0000}))),
        .out_valid (p2_valid),
        .out_x     (p2_x),
        .out_z     (p2_z)
    );

    always_ff @(posedge clk)
    begin
        yaw_dly_reg[0] <= m_yaw_reg;
        for (int i = 1; i <= CORDIC_STEPS; i++)
            yaw_dly_reg[i] <= yaw_dly_reg[i-1];
    end

    // output stage: round to Q2.13, negate pitch
    logic done_reg;
    rsp_t rsp_reg;
    logic p2_mag_sign;

    assign p2_mag_sign = p2_x[CW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p2_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.yaw   <= to_q213(yaw_dly_reg[CORDIC_STEPS]);
        rsp_reg.pitch <= to_q213(-p2_z);
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`include "assert_macros.svh"

    `ASSERT_CLK(a_done_follows_start, start |-> ##LAT done, "result missing")
    `ASSERT_CLK(a_done_has_start, done |-> $past(start, LAT), "spurious result")
    `ASSERT_CLK(a_yaw_range, done |-> (rsp.yaw <= PI_Q213 && rsp.yaw >= -PI_Q213), "yaw range")
    `ASSERT_NEVER(a_mag_pos, p2_valid && p2_mag_sign, "negative magnitude")

endmodule
`default_nettype wire

@@ dv/camera_look_at_yaw_pitch_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// camera_look_at_yaw_pitch_core_tb
// Drives aim requests and APB offset writes into the look-at core and checks
// every yaw/pitch result against a predictor kept in the bench itself.
// ---------------------------------------------------------------------------
module camera_look_at_yaw_pitch_core_tb;
    import lac_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS + 6;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic signed [31:0] ofs_x, ofs_y, ofs_z;
    rsp_t               aim_queue[$];
    int                 n_bad;
    int                 send_gap_pct;

    camera_look_at_yaw_pitch_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("camera_look_at_yaw_pitch_core: mismatch");
        $finish;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // vectoring CORDIC; returns Q20 angle of (x, y), gained magnitude in mag
    function automatic longint vector_angle(longint y, longint x, output longint mag);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = HALF_PI_Q20;
            end
            else
            begin
                x = -y;
                y = t;
                z = -HALF_PI_Q20;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                z += longint'(ATAN_Q20[i]);
            end
            else if (y < 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(ATAN_Q20[i]);
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic logic signed [15:0] angle_q213(longint z);
        longint a;
        a = floor_shift(z + 64, 7);
        if (a > 25736)
            a = 25736;
        if (a < -25736)
            a = -25736;
        return a[15:0];
    endfunction

    function automatic rsp_t aim_angles(req_t r);
        longint tx, ty, tz, dx, dy, dz, mag, h, yw, pt;
        rsp_t   o;
        if (r.action == ACT_LOCAL)
        begin
            tx = clamp32(longint'(r.node_local_x) + ofs_x);
            ty = clamp32(longint'(r.node_local_y) + ofs_y);
            tz = clamp32(longint'(r.node_local_z) + ofs_z);
        end
        else if (r.action == ACT_DIRECT)
        begin
            tx = r.node_world_x;
            ty = r.node_world_y;
            tz = r.node_world_z;
        end
        else
        begin
            tx = clamp32(longint'(r.node_world_x) + ofs_x);
            ty = clamp32(longint'(r.node_world_y) + ofs_y);
            tz = clamp32(longint'(r.node_world_z) + ofs_z);
        end
        dx = clamp32(longint'(r.cam_x) - tx);
        dy = clamp32(longint'(r.cam_y) - ty);
        dz = clamp32(longint'(r.cam_z) - tz);
        yw = vector_angle(dx * 65536, dz * 65536, mag);
        h = floor_shift(floor_shift(mag, 8) * longint'(INV_GAIN_Q16), 8);
        pt = vector_angle(dy * 65536, h, mag);
        o.yaw = angle_q213(yw);
        o.pitch = angle_q213(-pt);
        return o;
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (aim_queue.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result yaw=%0d pitch=%0d", rsp.yaw, rsp.pitch);
            end
            else
            begin
                want = aim_queue.pop_front();
                if (rsp.yaw !== want.yaw || rsp.pitch !== want.pitch)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("bad result: exp yaw=%0d pitch=%0d got yaw=%0d pitch=%0d",
                                 want.yaw, want.pitch, rsp.yaw, rsp.pitch);
                end
            end
        end
    end

    task automatic write_offset(logic [1:0] idx, logic signed [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_OFFSET_X: ofs_x = val;
            REG_OFFSET_Y: ofs_y = val;
            default:      ofs_z = val;
        endcase
    endtask

    task automatic set_offsets(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        write_offset(REG_OFFSET_X, x);
        write_offset(REG_OFFSET_Y, y);
        write_offset(REG_OFFSET_Z, z);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_aim(req_t r);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        req = r;
        start = 1'b1;
        do @(posedge clk); while (busy);
        aim_queue.push_back(aim_angles(r));
        @(negedge clk);
    endtask

    task automatic drain();
        int guard;
        start = 1'b0;
        guard = 0;
        while (aim_queue.size() != 0 && guard < 10000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_pos(int sel);
        case (sel)
            0: return $urandom;
            1: return $signed($urandom_range(2000000)) - 1000000;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(65536 * 200)) - 65536 * 100;
        endcase
    endfunction

    function automatic req_t rand_aim();
        req_t r;
        int   s;
        s = $urandom_range(3);
        r.action = 2'($urandom_range(3));
        r.cam_x = rand_pos(s == 0 ? $urandom_range(3) : s);
        r.cam_y = rand_pos(s == 0 ? $urandom_range(3) : s);
        r.cam_z = rand_pos(s == 0 ? $urandom_range(3) : s);
        r.node_local_x = rand_pos(s);
        r.node_local_y = rand_pos(s);
        r.node_local_z = rand_pos(s);
        r.node_world_x = rand_pos(s);
        r.node_world_y = rand_pos(s);
        r.node_world_z = rand_pos(s);
        // land the target on the camera now and then, or on its vertical axis
        if ($urandom_range(15) == 0)
        begin
            r.action = ACT_DIRECT;
            r.node_world_x = r.cam_x;
            r.node_world_z = r.cam_z;
            if ($urandom_range(1))
                r.node_world_y = r.cam_y;
        end
        return r;
    endfunction

    task automatic test_directed();
        req_t r;
        logic signed [31:0] ext[4];
        ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd65536};
        set_offsets(32'sd0, 32'sd0, 32'sd0);
        // camera on target, pure vertical, negative z with zero and negative x, then extremes for each action
        r = '0;
        r.action = ACT_DIRECT;
        send_aim(r);
        r.cam_y = 32'sd65536;
        send_aim(r);
        r.cam_y = 32'sd0;
        r.cam_z = -32'sd65536;
        send_aim(r);
        r.cam_x = -32'sd65536;
        send_aim(r);
        for (int a = 0; a < 4; a++)
        begin
            for (int e = 0; e < 4; e++)
            begin
                r.action = 2'(a);
                r.cam_x = ext[e];
                r.cam_y = ext[(e + 1) % 4];
                r.cam_z = ext[(e + 2) % 4];
                r.node_local_x = ext[(e + 3) % 4];
                r.node_local_y = ext[e];
                r.node_local_z = ext[(e + 1) % 4];
                r.node_world_x = ext[(e + 2) % 4];
                r.node_world_y = ext[(e + 3) % 4];
                r.node_world_z = ext[e];
                if (a * 4 + e < 18)
                    send_aim(r);
            end
        end
        drain();
        // saturating sums with extreme offsets
        set_offsets(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        r.action = ACT_WORLD;
        send_aim(r);
        r.action = ACT_LOCAL;
        send_aim(r);
        drain();
    endtask

    task automatic test_random(int count, int gap);
        send_gap_pct = gap;
        set_offsets(rand_pos($urandom_range(3)), rand_pos($urandom_range(3)),
                    rand_pos($urandom_range(3)));
        for (int i = 0; i < count; i++)
        begin
            send_aim(rand_aim());
            if (i % 100 == 99)
                start = 1'b0;
            if (i % 100 == 99 && $urandom_range(1))
            begin
                drain();
                set_offsets(rand_pos($urandom_range(3)), rand_pos($urandom_range(3)),
                            rand_pos($urandom_range(3)));
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ofs_x = 0;
        ofs_y = 0;
        ofs_z = 0;
        n_bad = 0;
        send_gap_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(420, 18);
        test_random(420, 73);
        test_random(420, 0);
        set_offsets(32'sd0, 32'sd0, 32'sd0);
        if (aim_queue.size() == 0 && n_bad == 0)
            $display("camera_look_at_yaw_pitch_core: match");
        else
            $display("camera_look_at_yaw_pitch_core: mismatch");
        $finish;
    end
endmodule
